/* hw/rtl/eac_pkg.sv */
// Shared types, constants and the arctangent table for the Euler angle to quaternion converter.
package eac_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ANG_W = 35;
   localparam int XY_W = 33;
   localparam int PAIR_W = 34;
   localparam int TRIPLE_W = PAIR_W + XY_W;
   localparam int SUM_W = TRIPLE_W + 1;
   localparam int SHIFT_W = 5;

   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [ANG_W-1:0] ANG_PI = 35'sd3373259426;
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 35'sd1686629713;
   localparam logic signed [15:0] QMAX = 16'sd16384;
   localparam logic signed [15:0] QMIN = -16'sd16384;

   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [ANG_W-1:0] z;
      logic                    neg;
   } rot_type;

   // Lane 0 carries heading, lane 1 attitude and lane 2 bank.
   typedef rot_type [2:0] trio_type;

   function automatic logic signed [ANG_W-1:0] atan_entry(input logic [SHIFT_W-1:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0: v = 32'h3243F6A8;   5'd1: v = 32'h1DAC6705;
         5'd2: v = 32'h0FADBAFC;   5'd3: v = 32'h07F56EA6;
         5'd4: v = 32'h03FEAB76;   5'd5: v = 32'h01FFD55B;
         5'd6: v = 32'h00FFFAAA;   5'd7: v = 32'h007FFF55;
         5'd8: v = 32'h003FFFEA;   5'd9: v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;  5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;  5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;  5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;  5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;  5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;  5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;  5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;  5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;  5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;  5'd29: v = 32'h00000002;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return signed'({3'b000, v});
   endfunction

   // Halves the angle, scales it to units of 2^-30 and folds it into [-pi/2, pi/2].
   function automatic rot_type reduce(input logic signed [15:0] angle);
      rot_type r;
      logic signed [ANG_W-1:0] z;
      z = signed'({{(ANG_W-33){angle[15]}}, angle, 17'b0});
      r.x = CORDIC_GAIN;
      r.y = '0;
      r.neg = 1'b0;
      if (z > ANG_HALF_PI) begin
         r.z = z - ANG_PI;
         r.neg = 1'b1;
      end else if (z < -ANG_HALF_PI) begin
         r.z = z + ANG_PI;
         r.neg = 1'b1;
      end else begin
         r.z = z;
      end
      return r;
   endfunction

endpackage

/* hw/rtl/eac_cell.sv */
// One CORDIC rotation step applied to the three angle lanes, with its pipeline register.
module eac_cell
   import eac_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic [SHIFT_W-1:0]  shift,
   input  logic                valid_in,
   input  trio_type            rot_in,
   output logic                valid_out,
   output trio_type            rot_out
);

   logic     valid_ff;
   trio_type rot_ff;
   trio_type rot_in_next;
   logic signed [ANG_W-1:0] angle_step;

   always_comb begin
      angle_step = atan_entry(shift);
      for (int k = 0; k < 3; k++) begin
         rot_in_next[k].neg = rot_in[k].neg;
         if (rot_in[k].z >= 0) begin
            rot_in_next[k].x = rot_in[k].x - (rot_in[k].y >>> shift);
            rot_in_next[k].y = rot_in[k].y + (rot_in[k].x >>> shift);
            rot_in_next[k].z = rot_in[k].z - angle_step;
         end else begin
            rot_in_next[k].x = rot_in[k].x + (rot_in[k].y >>> shift);
            rot_in_next[k].y = rot_in[k].y - (rot_in[k].x >>> shift);
            rot_in_next[k].z = rot_in[k].z + angle_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         rot_ff <= rot_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign rot_out = rot_ff;

endmodule

/* hw/rtl/eac_product.sv */
// Sign fix, three-factor products, rounding and saturation into the quaternion result.
module eac_product
   import eac_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               valid_in,
   input  trio_type           rot_in,
   output logic               valid_out,
   output logic signed [15:0] quat_w,
   output logic signed [15:0] quat_x,
   output logic signed [15:0] quat_y,
   output logic signed [15:0] quat_z
);

   logic [3:0] valid_ff;
   logic signed [XY_W-1:0] cos_ff [3];
   logic signed [XY_W-1:0] sin_ff [3];
   logic signed [PAIR_W-1:0] pair_ff [4];
   logic signed [XY_W-1:0] c3_ff;
   logic signed [XY_W-1:0] s3_ff;
   logic signed [TRIPLE_W-1:0] tri_ff [8];
   logic signed [15:0] quat_ff [4];

   logic signed [PAIR_W-1:0] pair_in [4];
   logic signed [TRIPLE_W-1:0] tri_in [8];
   logic signed [15:0] quat_in [4];
   logic signed [SUM_W-1:0] sum [4];

   function automatic logic signed [PAIR_W-1:0] pair_mul(input logic signed [XY_W-1:0] a,
                                                        input logic signed [XY_W-1:0] b);
      logic signed [2*XY_W-1:0] p;
      p = a * b;
      return PAIR_W'(p >>> 30);
   endfunction

   function automatic logic signed [15:0] to_q14(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      r = (v + (SUM_W'(1) <<< 45)) >>> 46;
      if (r > SUM_W'(QMAX)) begin
         return QMAX;
      end else if (r < SUM_W'(QMIN)) begin
         return QMIN;
      end
      return r[15:0];
   endfunction

   always_comb begin
      pair_in[0] = pair_mul(cos_ff[0], cos_ff[1]);
      pair_in[1] = pair_mul(sin_ff[0], sin_ff[1]);
      pair_in[2] = pair_mul(sin_ff[0], cos_ff[1]);
      pair_in[3] = pair_mul(cos_ff[0], sin_ff[1]);
      tri_in[0] = pair_ff[0] * c3_ff;
      tri_in[1] = pair_ff[1] * s3_ff;
      tri_in[2] = pair_ff[1] * c3_ff;
      tri_in[3] = pair_ff[0] * s3_ff;
      tri_in[4] = pair_ff[2] * c3_ff;
      tri_in[5] = pair_ff[3] * s3_ff;
      tri_in[6] = pair_ff[3] * c3_ff;
      tri_in[7] = pair_ff[2] * s3_ff;
      sum[0] = SUM_W'(tri_ff[0]) - SUM_W'(tri_ff[1]);
      sum[1] = SUM_W'(tri_ff[2]) + SUM_W'(tri_ff[3]);
      sum[2] = SUM_W'(tri_ff[4]) + SUM_W'(tri_ff[5]);
      sum[3] = SUM_W'(tri_ff[6]) - SUM_W'(tri_ff[7]);
      for (int k = 0; k < 4; k++) begin
         quat_in[k] = to_q14(sum[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[2:0], valid_in};
      end
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            cos_ff[k] <= rot_in[k].neg ? -rot_in[k].x : rot_in[k].x;
            sin_ff[k] <= rot_in[k].neg ? -rot_in[k].y : rot_in[k].y;
         end
         for (int k = 0; k < 4; k++) begin
            pair_ff[k] <= pair_in[k];
            quat_ff[k] <= quat_in[k];
         end
         c3_ff <= cos_ff[2];
         s3_ff <= sin_ff[2];
         for (int k = 0; k < 8; k++) begin
            tri_ff[k] <= tri_in[k];
         end
      end
   end

   assign valid_out = valid_ff[3];
   assign quat_w = quat_ff[0];
   assign quat_x = quat_ff[1];
   assign quat_y = quat_ff[2];
   assign quat_z = quat_ff[3];

endmodule

/* hw/rtl/euler_angles_to_quaternion_core.sv */
// Top level of the Euler angle to unit quaternion converter.
//
//   channel  direction  ports
//   req      in         req_valid, req_ready, req_bank/heading/attitude_angle
//   rsp      out        rsp_valid, rsp_ready, rsp_quat_w/x/y/z
//
// One transfer is accepted per cycle while the pipeline is not halted. The pipeline holds one
// range-reduction stage, one CORDIC cell per step, and four product and rounding stages.
// The whole pipeline advances together and halts only while a result waits on rsp.
// Reset clears the valid bits of every stage; data registers are not reset.
module euler_angles_to_quaternion_core
   import eac_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_bank_angle,
   input  logic signed [15:0] req_heading_angle,
   input  logic signed [15:0] req_attitude_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_quat_w,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z
);

   logic     advance;
   logic     in_valid_ff;
   trio_type in_ff;
   logic     chain_valid [CORDIC_STEPS+1];
   trio_type chain_rot [CORDIC_STEPS+1];

   assign advance = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
      if (advance) begin
         in_ff[0] <= reduce(req_heading_angle);
         in_ff[1] <= reduce(req_attitude_angle);
         in_ff[2] <= reduce(req_bank_angle);
      end
   end

   assign chain_valid[0] = in_valid_ff;
   assign chain_rot[0] = in_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      eac_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .shift     (SHIFT_W'(i)),
         .valid_in  (chain_valid[i]),
         .rot_in    (chain_rot[i]),
         .valid_out (chain_valid[i+1]),
         .rot_out   (chain_rot[i+1])
      );
   end

   eac_product u_product (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .valid_in  (chain_valid[CORDIC_STEPS]),
      .rot_in    (chain_rot[CORDIC_STEPS]),
      .valid_out (rsp_valid),
      .quat_w    (rsp_quat_w),
      .quat_x    (rsp_quat_x),
      .quat_y    (rsp_quat_y),
      .quat_z    (rsp_quat_z)
   );

endmodule

/* test/tb_euler_angles_to_quaternion_core.sv */
// Self-checking testbench for the Euler angle to quaternion converter.
module tb_euler_angles_to_quaternion_core;
   import eac_pkg::*;

   typedef struct packed {
      logic signed [15:0] w;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } quat_type;

   localparam longint RUN_LIMIT = 2000000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_bank_angle;
   logic signed [15:0] req_heading_angle;
   logic signed [15:0] req_attitude_angle;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_quat_w;
   logic signed [15:0] rsp_quat_x;
   logic signed [15:0] rsp_quat_y;
   logic signed [15:0] rsp_quat_z;

   quat_type expected_quats[$];
   int       fail_count;
   int       send_idle_pct;
   int       stall_pct;
   longint   cycle_count;

   euler_angles_to_quaternion_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   task automatic half_cos_sin(input logic signed [15:0] angle,
                               output longint c, output longint s);
      longint z, x, y, t;
      longint atab[32];
      bit     neg;
      atab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
               64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
               64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
               64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
               64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
               64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
               64'h00000001, 64'h00000000};
      z = longint'(angle) * 131072;
      x = 64'h26DD3B6A;
      y = 0;
      neg = 1'b0;
      if (z > 64'sd1686629713) begin
         z = z - 64'sd3373259426;
         neg = 1'b1;
      end else if (z < -64'sd1686629713) begin
         z = z + 64'sd3373259426;
         neg = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
         if (z >= 0) begin
            t = x - floor_shift(y, i);
            y = y + floor_shift(x, i);
            z = z - atab[i];
         end else begin
            t = x + floor_shift(y, i);
            y = y - floor_shift(x, i);
            z = z + atab[i];
         end
         x = t;
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
   endtask

   // Triple products can exceed 64 bits, so they are carried at 128 bits.
   function automatic logic signed [127:0] triple(longint a, longint b, longint c);
      logic signed [127:0] ab;
      ab = 128'(a) * 128'(b);
      return (ab >>> 30) * 128'(c);
   endfunction

   function automatic logic signed [15:0] round_q14(logic signed [127:0] v);
      logic signed [127:0] r;
      r = (v + (128'sd1 <<< 45)) >>> 46;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
   endfunction

   task automatic predict_quat(input logic signed [15:0] bank, heading, attitude,
                               output quat_type q);
      longint c1, s1, c2, s2, c3, s3;
      half_cos_sin(heading, c1, s1);
      half_cos_sin(attitude, c2, s2);
      half_cos_sin(bank, c3, s3);
      q.w = round_q14(triple(c1, c2, c3) - triple(s1, s2, s3));
      q.x = round_q14(triple(s1, s2, c3) + triple(c1, c2, s3));
      q.y = round_q14(triple(s1, c2, c3) + triple(c1, s2, s3));
      q.z = round_q14(triple(c1, s2, c3) - triple(s1, c2, s3));
   endtask

   task automatic send_angles(input logic signed [15:0] bank, heading, attitude);
      quat_type q;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_bank_angle <= bank;
      req_heading_angle <= heading;
      req_attitude_angle <= attitude;
      predict_quat(bank, heading, attitude, q);
      do @(posedge clock); while (!req_ready);
      expected_quats.push_back(q);
      @(negedge clock);
   endtask

   // The ready line is redrawn every falling edge; results are checked at the rising edge.
   always @(negedge clock) begin
      if (!reset) rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      quat_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_quats.size() == 0) begin
            $display("%0t: unexpected transfer w=%0d x=%0d y=%0d z=%0d", $time,
                     rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z);
            fail_count++;
         end else begin
            want = expected_quats.pop_front();
            if (rsp_quat_w !== want.w || rsp_quat_x !== want.x ||
                rsp_quat_y !== want.y || rsp_quat_z !== want.z) begin
               $display("%0t: expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
                        $time, want.w, want.x, want.y, want.z,
                        rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z);
               fail_count++;
            end
         end
      end
   end

   task automatic test_extremes();
      logic signed [15:0] corner[8];
      corner = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001,
                 16'sd6434, 16'sd6435, -16'sd6435};
      for (int i = 0; i < 8; i++) send_angles(corner[i], corner[i], corner[i]);
      for (int i = 0; i < 8; i++) send_angles(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]);
      send_angles(16'sd12868, 16'sd0, 16'sd0);
      send_angles(16'sd0, 16'sd12868, 16'sd0);
      send_angles(16'sd0, 16'sd0, 16'sd12868);
      send_angles(-16'sd12868, 16'sd12868, -16'sd12868);
   endtask

   task automatic test_random(input int count, input int idle, input int stall);
      send_idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0)
            send_angles(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                        16'($urandom_range(16'hFFFF)));
         else
            send_angles(16'($signed($urandom_range(25736)) - 12868),
                        16'($signed($urandom_range(25736)) - 12868),
                        16'($signed($urandom_range(25736)) - 12868));
      end
   endtask

   task automatic test_drain_pause();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_quats.size() != 0) @(negedge clock);
      send_angles(16'sd1000, -16'sd2000, 16'sd3000);
   endtask

   initial begin
      fail_count = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_ready = 1'b0;
      req_bank_angle = '0;
      req_heading_angle = '0;
      req_attitude_angle = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_random(480, 0, 0);
      test_random(480, 74, 0);
      test_drain_pause();
      test_random(480, 0, 74);
      test_random(480, 23, 23);
      send_idle_pct = 0;
      stall_pct = 0;
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_quats.size() != 0) @(negedge clock);
      repeat (CORDIC_STEPS + 20) @(negedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* euler_angles_to_quaternion_core.f */
hw/rtl/eac_pkg.sv
hw/rtl/eac_cell.sv
hw/rtl/eac_product.sv
hw/rtl/euler_angles_to_quaternion_core.sv
test/tb_euler_angles_to_quaternion_core.sv
